@@ design/itrd_pkg.sv @@
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and helpers for the integer to radix digit core.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int unsigned VALUE_BITS = 31;
  localparam int unsigned RADIX_W    = 5;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned QUO_W      = 4;
  localparam int unsigned QSEL_W     = 2;
  localparam int unsigned PROD_W     = VALUE_BITS + RADIX_W;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_UPPER_A = CHAR_W'(65);
  localparam logic [QUO_W-1:0]   DECIMAL_DIGITS = QUO_W'(10);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
    logic [QSEL_W-1:0]     qtop;   // top quotient bit position per digit
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] v;
    v = r;
    if (r < RADIX_MIN) begin
      v = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      v = RADIX_MAX;
    end
    return v;
  endfunction

  function automatic logic [QSEL_W-1:0] quo_top(input logic [RADIX_W-1:0] r);
    logic [QSEL_W-1:0] t;
    if (r <= RADIX_W'(2)) begin
      t = QSEL_W'(0);
    end else if (r <= RADIX_W'(4)) begin
      t = QSEL_W'(1);
    end else if (r <= RADIX_W'(8)) begin
      t = QSEL_W'(2);
    end else begin
      t = QSEL_W'(3);
    end
    return t;
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [QUO_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_DIGITS) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_UPPER_A + CHAR_W'(d - DECIMAL_DIGITS);
    end
    return c;
  endfunction

endpackage

@@ design/itrd_front.sv @@
// ----------------------------------------------------------------------------
// itrd_front
// Holds the radix register, takes start commands and classifies each value.
// ----------------------------------------------------------------------------
module itrd_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [itrd_pkg::RADIX_W-1:0]       cfg_data_i,
  input  logic                               start_i,
  input  logic [itrd_pkg::VALUE_BITS-1:0]    value_i,
  input  itrd_pkg::queue_stat_t              qstat_i,
  output logic                               busy_o,
  output logic                               push_o,
  output itrd_pkg::item_t                    item_o
);

  logic [itrd_pkg::RADIX_W-1:0] radix_q, radix_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    radix_d = radix_q;
    if (cfg_valid_i) begin
      radix_d = itrd_pkg::clamp_radix(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itrd_pkg::RADIX_RESET;
    end else begin
      radix_q <= radix_d;
    end
  end

  assign busy_o = qstat_i.full;
  assign push_o = start_i & ~qstat_i.full;

  always_comb begin
    item_o.value = value_i;
    item_o.radix = radix_q;
    item_o.qtop  = itrd_pkg::quo_top(radix_q);
  end

endmodule

@@ design/itrd_queue.sv @@
// ----------------------------------------------------------------------------
// itrd_queue
// Two-entry queue between the command front and the digit engine.
// ----------------------------------------------------------------------------
module itrd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  itrd_pkg::item_t       item_i,
  input  logic                  pop_i,
  output itrd_pkg::item_t       item_o,
  output itrd_pkg::queue_stat_t stat_o
);

  itrd_pkg::item_t                  mem_q [itrd_pkg::QDEPTH];
  logic [itrd_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [itrd_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [itrd_pkg::QCNT_W-1:0]      cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == itrd_pkg::QPTR_W'(itrd_pkg::QDEPTH - 1)) ?
                 '0 : wr_ptr_q + itrd_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == itrd_pkg::QPTR_W'(itrd_pkg::QDEPTH - 1)) ?
                 '0 : rd_ptr_q + itrd_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + itrd_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - itrd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.valid = (cnt_q != '0);
  assign stat_o.full  = (cnt_q == itrd_pkg::QCNT_W'(itrd_pkg::QDEPTH));

endmodule

@@ design/itrd_engine.sv @@
// ----------------------------------------------------------------------------
// itrd_engine
// Finds the top radix power, then produces digits by restoring division
// against that power while scaling the remainder by the radix.
// ----------------------------------------------------------------------------
module itrd_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  itrd_pkg::queue_stat_t             qstat_i,
  input  itrd_pkg::item_t                   item_i,
  output logic                              pop_o,
  output logic                              digit_valid_o,
  output logic [itrd_pkg::CHAR_W-1:0]       digit_char_o,
  output logic                              last_digit_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_SCALE  = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [itrd_pkg::VALUE_BITS-1:0]   value_q, value_d;
  logic [itrd_pkg::RADIX_W-1:0]      radix_q, radix_d;
  logic [itrd_pkg::QSEL_W-1:0]       qtop_q, qtop_d;
  logic [itrd_pkg::VALUE_BITS-1:0]   pow_q, pow_d;
  logic [itrd_pkg::PROD_W-1:0]       next_q, next_d;
  logic [itrd_pkg::PROD_W-1:0]       rem_q, rem_d;
  logic [itrd_pkg::QSEL_W-1:0]       k_q, k_d;
  logic [itrd_pkg::QUO_W-1:0]        quo_q, quo_d;
  logic [itrd_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic                              ovalid_q, ovalid_d;
  logic [itrd_pkg::CHAR_W-1:0]       ochar_q, ochar_d;
  logic                              olast_q, olast_d;

  logic [itrd_pkg::PROD_W-1:0]       mul_a;
  logic [itrd_pkg::PROD_W-1:0]       mul_res;
  logic [itrd_pkg::PROD_W-1:0]       sub;

  // one shared multiplier: power search or remainder scaling
  assign mul_a   = (state_q == S_SCALE) ? rem_q : next_q;
  assign mul_res = itrd_pkg::PROD_W'(mul_a * radix_q);
  assign sub     = itrd_pkg::PROD_W'(pow_q) << k_q;

  always_comb begin
    state_d  = state_q;
    value_d  = value_q;
    radix_d  = radix_q;
    qtop_d   = qtop_q;
    pow_d    = pow_q;
    next_d   = next_q;
    rem_d    = rem_q;
    k_d      = k_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    ovalid_d = 1'b0;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    pop_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (qstat_i.valid) begin
          pop_o   = 1'b1;
          value_d = item_i.value;
          radix_d = item_i.radix;
          qtop_d  = item_i.qtop;
          pow_d   = itrd_pkg::VALUE_BITS'(1);
          next_d  = itrd_pkg::PROD_W'(item_i.radix);
          cnt_d   = itrd_pkg::CNT_W'(1);
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (next_q <= itrd_pkg::PROD_W'(value_q)) begin
          pow_d  = next_q[itrd_pkg::VALUE_BITS-1:0];
          next_d = mul_res;
          cnt_d  = cnt_q + itrd_pkg::CNT_W'(1);
        end else begin
          rem_d   = itrd_pkg::PROD_W'(value_q);
          k_d     = qtop_q;
          quo_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_q >= sub) begin
          rem_d = rem_q - sub;
          quo_d = quo_q | (itrd_pkg::QUO_W'(1) << k_q);
        end
        if (k_q == '0) begin
          ovalid_d = 1'b1;
          ochar_d  = itrd_pkg::to_ascii(quo_d);
          olast_d  = (cnt_q == itrd_pkg::CNT_W'(1));
          cnt_d    = cnt_q - itrd_pkg::CNT_W'(1);
          state_d  = (cnt_q == itrd_pkg::CNT_W'(1)) ? S_IDLE : S_SCALE;
        end else begin
          k_d = k_q - itrd_pkg::QSEL_W'(1);
        end
      end
      S_SCALE: begin
        rem_d   = mul_res;
        k_d     = qtop_q;
        quo_d   = '0;
        state_d = S_DIV;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    radix_q <= radix_d;
    qtop_q  <= qtop_d;
    pow_q   <= pow_d;
    next_q  <= next_d;
    rem_q   <= rem_d;
    k_q     <= k_d;
    quo_q   <= quo_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign digit_valid_o = ovalid_q;
  assign digit_char_o  = ochar_q;
  assign last_digit_o  = olast_q;

endmodule

@@ design/integer_to_radix_digits_core.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts a non-negative integer into uppercase ASCII digits of a radix
// from 2 to 16, most significant digit first, marking the last digit.
// ----------------------------------------------------------------------------
// A value is taken on a clock edge with start_i high and busy_o low and waits
// in a two-entry queue; busy_o rises only when that queue is full. Each digit
// appears on digit_char_o for one cycle with digit_valid_o high and must be
// taken then, as the core has no way to hold it. For each value the digit
// engine takes the value from the queue, searches for the top power with the
// engine's one multiplier, then gives each digit b compare-and-subtract steps,
// where b is 1 for radix 2, 2 for radix 3 to 4, 3 for radix 5 to 8 and 4 for
// radix 9 to 16, and every digit but the last one remainder scaling step
// through the same multiplier. The engine takes no new value until the last
// digit of the current one is produced. Digits of one value never come out on
// consecutive cycles. Radix writes are always ready and clamp into 2 to 16;
// they take effect for values accepted later.
module integer_to_radix_digits_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [itrd_pkg::RADIX_W-1:0]      cfg_data_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [itrd_pkg::VALUE_BITS-1:0]   value_i,
  output logic                              digit_valid_o,
  output logic [itrd_pkg::CHAR_W-1:0]       digit_char_o,
  output logic                              last_digit_o
);

  itrd_pkg::queue_stat_t qstat;
  itrd_pkg::item_t       front_item;
  itrd_pkg::item_t       head_item;
  logic                  push;
  logic                  pop;

  itrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start_i),
    .value_i     (value_i),
    .qstat_i     (qstat),
    .busy_o      (busy_o),
    .push_o      (push),
    .item_o      (front_item)
  );

  itrd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (qstat)
  );

  itrd_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .item_i        (head_item),
    .pop_o         (pop),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

  // digits never come out on consecutive cycles
  a_digit_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |=> !digit_valid_o)
    else $error("digit strobe on consecutive cycles");

  // only hex digit characters are produced
  a_digit_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |-> ((digit_char_o >= itrd_pkg::CHAR_W'(48) &&
                        digit_char_o <= itrd_pkg::CHAR_W'(57)) ||
                       (digit_char_o >= itrd_pkg::CHAR_W'(65) &&
                        digit_char_o <= itrd_pkg::CHAR_W'(70))))
    else $error("digit character out of range");

  // radix held by the front stays clamped
  a_radix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_item.radix >= itrd_pkg::RADIX_MIN) &&
    (front_item.radix <= itrd_pkg::RADIX_MAX))
    else $error("radix register outside clamp range");

  // a transfer into the queue leaves it non-empty on the next cycle
  a_queue_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> qstat.valid)
    else $error("queue empty after push");

endmodule

@@ sim/itrd_digit_checker.sv @@
// ----------------------------------------------------------------------------
// itrd_digit_checker
// Watches the radix, value and digit channels of the integer to radix digit
// core. Keeps its own radix copy, spells every accepted value into the
// expected digit string and compares each digit transfer with it.
// ----------------------------------------------------------------------------
module itrd_digit_checker
  import itrd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [RADIX_W-1:0]    cfg_data_i,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  digit_valid_i,
  input  logic [CHAR_W-1:0]     digit_char_i,
  input  logic                  last_digit_i,
  output int                    owed_o,
  output int                    fails_o
);

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } glyph_t;

  glyph_t              digits_due[$];
  logic [RADIX_W-1:0]  radix_q;

  // digits of v in radix r, most significant first, last one marked
  function automatic void spell_value(input logic [VALUE_BITS-1:0] v,
                                      input logic [RADIX_W-1:0] r);
    glyph_t                word[$];
    glyph_t                g;
    logic [VALUE_BITS-1:0] rest;
    int unsigned           d;
    rest = v;
    do begin
      d = int'(rest % VALUE_BITS'(r));
      if (d < DECIMAL_DIGITS) begin
        g.ch = ASCII_ZERO + CHAR_W'(d);
      end else begin
        g.ch = ASCII_UPPER_A + CHAR_W'(d - DECIMAL_DIGITS);
      end
      g.last = 1'b0;
      word.push_front(g);
      rest = rest / VALUE_BITS'(r);
    end while (rest != '0);
    word[word.size()-1].last = 1'b1;
    foreach (word[i]) digits_due.push_back(word[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    glyph_t want;
    if (!rst_ni) begin
      radix_q = RADIX_RESET;
      digits_due.delete();
      fails_o = 0;
      owed_o  = 0;
    end else begin
      if (digit_valid_i) begin
        if (digits_due.size() == 0) begin
          $display("%0t: digit transfer with none expected, got char %0d last %b",
                   $time, digit_char_i, last_digit_i);
          fails_o++;
        end else begin
          want = digits_due.pop_front();
          if (digit_char_i !== want.ch) begin
            $display("%0t: digit char mismatch, expected %0d got %0d",
                     $time, want.ch, digit_char_i);
            fails_o++;
          end
          if (last_digit_i !== want.last) begin
            $display("%0t: last digit mismatch, expected %b got %b",
                     $time, want.last, last_digit_i);
            fails_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        spell_value(value_i, radix_q);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i < RADIX_MIN) begin
          radix_q = RADIX_MIN;
        end else if (cfg_data_i > RADIX_MAX) begin
          radix_q = RADIX_MAX;
        end else begin
          radix_q = cfg_data_i;
        end
      end
      owed_o = digits_due.size();
    end
  end

endmodule

@@ sim/tb_integer_to_radix_digits_core.sv @@
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits_core
// Drives radix writes and values into the integer to radix digit core: a
// directed set of corner values over the radix extremes, then random phases
// each with a fresh radix. A side checker predicts and compares every digit.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits_core;
  import itrd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 105;
  localparam logic [VALUE_BITS-1:0] VALUE_ALL = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [RADIX_W-1:0]    cfg_data_i;
  logic                  start_i;
  logic                  busy_o;
  logic [VALUE_BITS-1:0] value_i;
  logic                  digit_valid_o;
  logic [CHAR_W-1:0]     digit_char_o;
  logic                  last_digit_o;

  int                    owed;
  int                    fails;
  int                    quiet;
  int                    sent;
  int unsigned           cur_radix;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  integer_to_radix_digits_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

  itrd_digit_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .value_i       (value_i),
    .digit_valid_i (digit_valid_o),
    .digit_char_i  (digit_char_o),
    .last_digit_i  (last_digit_o),
    .owed_o        (owed),
    .fails_o       (fails)
  );

  // cycles without any transfer on any channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet <= 0;
    end else if ((start_i && !busy_o) || digit_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    bit calm;
    calm = (sent >= 60) && (sent < 100);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 16) begin
      start_i = 1'b0;
      value_i = VALUE_BITS'($urandom());
      @(negedge clk_i);
    end
    start_i = 1'b1;
    value_i = v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
  endtask

  // radix writes only once every digit owed has been transferred
  task automatic set_radix(input logic [RADIX_W-1:0] d);
    @(negedge clk_i);
    start_i = 1'b0;
    while (owed != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = RADIX_W'($urandom());
    if (d < RADIX_MIN) begin
      cur_radix = RADIX_MIN;
    end else if (d > RADIX_MAX) begin
      cur_radix = RADIX_MAX;
    end else begin
      cur_radix = d;
    end
  endtask

  function automatic logic [VALUE_BITS-1:0] draw_value(input int unsigned r);
    longint unsigned       p;
    longint unsigned       top;
    int unsigned           k;
    logic [VALUE_BITS-1:0] v;
    top = longint'(VALUE_ALL);
    case ($urandom_range(4))
      0: v = VALUE_BITS'($urandom());
      1: v = VALUE_BITS'($urandom() >> $urandom_range(31));
      2: begin
        // around a power of the radix, where the digit count steps
        p = 1;
        k = $urandom_range(30);
        repeat (k) if (p * r <= top) p = p * r;
        p = p + $urandom_range(2) - 1;
        if (p > top) p = top;
        v = VALUE_BITS'(p);
      end
      3: v = VALUE_BITS'($urandom_range(2 * r));
      default: v = $urandom_range(1) ? VALUE_ALL : '0;
    endcase
    return v;
  endfunction

  initial begin
    int random_sent;
    int n;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    start_i     = 1'b0;
    value_i     = '0;
    sent        = 0;
    cur_radix   = RADIX_RESET;
    random_sent = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // radix out of reset
    send_value('0);
    send_value(VALUE_ALL);
    send_value(VALUE_BITS'(9));
    send_value(VALUE_BITS'(10));
    send_value(VALUE_BITS'(1000000000));
    // write of zero clamps up to binary
    set_radix('0);
    send_value('0);
    send_value(VALUE_BITS'(1));
    send_value(VALUE_ALL);
    send_value(VALUE_BITS'(1) << (VALUE_BITS - 1));
    // all-ones write clamps down to hex
    set_radix('1);
    send_value(VALUE_BITS'(15));
    send_value(VALUE_ALL);
    send_value(VALUE_BITS'(16));
    send_value(VALUE_BITS'('h2BCDEF01));
    set_radix(RADIX_W'(1));
    send_value(VALUE_BITS'(5));
    set_radix(RADIX_W'(17));
    send_value(VALUE_BITS'(255));
    set_radix(RADIX_W'(3));
    send_value(VALUE_ALL);
    send_value(VALUE_BITS'(8));
    set_radix(RADIX_W'(7));
    send_value(VALUE_BITS'('h55555555));
    set_radix(RADIX_W'(8));
    send_value(VALUE_BITS'('h2AAAAAAA));

    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(5))
        0: set_radix(RADIX_W'($urandom_range(1)));
        1: set_radix(RADIX_W'($urandom_range(31, 16)));
        2: set_radix(RADIX_MIN);
        3: set_radix(RADIX_MAX);
        default: set_radix(RADIX_W'($urandom_range(16, 2)));
      endcase
      n = $urandom_range(14, 4);
      repeat (n) send_value(draw_value(cur_radix));
      random_sent += n;
    end

    @(negedge clk_i);
    start_i = 1'b0;
    while (owed != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
